@@ rtl/ssfmt_pkg.sv @@
// ----------------------------------------------------------------------------
// ssfmt_pkg
// Shared types, constants and lookup functions for the four digit
// seven-segment formatter.
// ----------------------------------------------------------------------------
package ssfmt_pkg;

  typedef logic [3:0]  digit_t;
  typedef logic [7:0]  seg_t;
  typedef logic [13:0] count_t;

  // scale thresholds
  localparam logic [31:0] SAT_LIMIT   = 32'd9999999;
  localparam logic [31:0] DIV1000_MIN = 32'd999999;
  localparam logic [31:0] DIV100_MIN  = 32'd99999;
  localparam logic [31:0] DIV10_MIN   = 32'd9999;

  // reciprocals for quotient by multiply and shift, exact below 2^24
  localparam int unsigned  RECIP_SHIFT = 34;
  localparam int unsigned  RECIP_W     = 31;
  localparam int unsigned  SCALE_IN_W  = 24;
  localparam int unsigned  PROD_W      = RECIP_W + SCALE_IN_W;
  localparam logic [30:0]  RECIP_1000  = 31'd17179870;
  localparam logic [30:0]  RECIP_100   = 31'd171798692;
  localparam logic [30:0]  RECIP_10    = 31'd1717986919;

  localparam count_t DISPLAY_MAX = 14'd9999;
  localparam count_t UNIT_1000   = 14'd1000;
  localparam count_t UNIT_100    = 14'd100;
  localparam count_t UNIT_10     = 14'd10;

  // point position codes
  localparam logic [2:0] PT_NONE   = 3'd0;
  localparam logic [2:0] PT_FIRST  = 3'd1;
  localparam logic [2:0] PT_SECOND = 3'd2;
  localparam logic [2:0] PT_THIRD  = 3'd3;
  localparam logic [2:0] PT_FOURTH = 3'd4;

  typedef struct packed {
    count_t     num;
    logic       keep;
    logic [2:0] point;
  } scaled_t;

  typedef struct packed {
    digit_t digit;
    count_t rest;
  } split_t;

  function automatic seg_t seg_of(digit_t d);
    seg_t s;
    case (d)
      4'd0:    s = 8'hfc;
      4'd1:    s = 8'h60;
      4'd2:    s = 8'hda;
      4'd3:    s = 8'hf2;
      4'd4:    s = 8'h66;
      4'd5:    s = 8'hb6;
      4'd6:    s = 8'hbe;
      4'd7:    s = 8'he0;
      4'd8:    s = 8'hfe;
      4'd9:    s = 8'hf6;
      default: s = 8'h00;
    endcase
    return s;
  endfunction

  // leading digit by parallel compare against multiples of unit
  function automatic split_t split_digit(count_t n, count_t unit);
    split_t      r;
    int unsigned k;
    r.digit = '0;
    r.rest  = n;
    for (k = 1; k < 10; k++) begin
      if (n >= count_t'(k) * unit) begin
        r.digit = digit_t'(k);
        r.rest  = n - count_t'(k) * unit;
      end
    end
    return r;
  endfunction

endpackage

@@ rtl/ssfmt_scale.sv @@
// ----------------------------------------------------------------------------
// ssfmt_scale
// Scales the input value to at most four decimal digits by a reciprocal
// multiply and saturates at 9999; registers the scaled beat.
// ----------------------------------------------------------------------------
module ssfmt_scale (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [31:0]       value,
  input  logic              keep,
  input  logic [2:0]        point,
  output logic              out_valid,
  input  logic              out_ready,
  output ssfmt_pkg::scaled_t out_item
);

  logic                             valid_r;
  ssfmt_pkg::scaled_t               item_r;
  ssfmt_pkg::scaled_t               item_nxt;
  logic [ssfmt_pkg::RECIP_W-1:0]    recip;
  logic                             use_div;
  logic                             sat;
  logic [ssfmt_pkg::PROD_W-1:0]     prod;
  ssfmt_pkg::count_t                quot;

  assign sat = value > ssfmt_pkg::SAT_LIMIT;

  always_comb begin
    use_div = 1'b1;
    recip   = ssfmt_pkg::RECIP_10;
    if (value > ssfmt_pkg::DIV1000_MIN) begin
      recip = ssfmt_pkg::RECIP_1000;
    end else if (value > ssfmt_pkg::DIV100_MIN) begin
      recip = ssfmt_pkg::RECIP_100;
    end else if (value > ssfmt_pkg::DIV10_MIN) begin
      recip = ssfmt_pkg::RECIP_10;
    end else begin
      use_div = 1'b0;
    end
  end

  assign prod = ssfmt_pkg::PROD_W'(value[ssfmt_pkg::SCALE_IN_W-1:0])
              * ssfmt_pkg::PROD_W'(recip);
  assign quot = prod[ssfmt_pkg::RECIP_SHIFT +: 14];

  always_comb begin
    item_nxt.keep  = keep;
    item_nxt.point = point;
    if (sat) begin
      item_nxt.num = ssfmt_pkg::DISPLAY_MAX;
    end else if (use_div) begin
      item_nxt.num = quot;
    end else begin
      item_nxt.num = value[13:0];
    end
  end

  assign in_ready  = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_item  = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= item_nxt;
    end
  end

  a_num_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r |-> item_r.num <= ssfmt_pkg::DISPLAY_MAX)
    else $error("scaled value above display range");

  a_beat_taken: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> valid_r)
    else $error("accepted beat lost in scale stage");

  a_saturate: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && sat |=> item_r.num == ssfmt_pkg::DISPLAY_MAX)
    else $error("large value not saturated");

endmodule

@@ rtl/ssfmt_digits.sv @@
// ----------------------------------------------------------------------------
// ssfmt_digits
// Splits the scaled value into four decimal digits, blanks leading zeros,
// maps each digit to segments, adds the point and registers the result.
// ----------------------------------------------------------------------------
module ssfmt_digits (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  ssfmt_pkg::scaled_t in_item,
  output logic               out_valid,
  input  logic               out_ready,
  output ssfmt_pkg::seg_t    seg_first,
  output ssfmt_pkg::seg_t    seg_second,
  output ssfmt_pkg::seg_t    seg_third,
  output ssfmt_pkg::seg_t    seg_fourth
);

  ssfmt_pkg::split_t s_thou;
  ssfmt_pkg::split_t s_hund;
  ssfmt_pkg::split_t s_tens;
  ssfmt_pkg::digit_t d_ones;
  logic [3:0]        blank;
  logic              valid_r;
  ssfmt_pkg::seg_t   seg0_r, seg1_r, seg2_r, seg3_r;
  ssfmt_pkg::seg_t   seg0_nxt, seg1_nxt, seg2_nxt, seg3_nxt;

  assign s_thou = ssfmt_pkg::split_digit(in_item.num, ssfmt_pkg::UNIT_1000);
  assign s_hund = ssfmt_pkg::split_digit(s_thou.rest, ssfmt_pkg::UNIT_100);
  assign s_tens = ssfmt_pkg::split_digit(s_hund.rest, ssfmt_pkg::UNIT_10);
  assign d_ones = s_tens.rest[3:0];

  // leading zero chain, left to right
  assign blank[0] = !in_item.keep && (s_thou.digit == '0);
  assign blank[1] = blank[0] && (s_hund.digit == '0);
  assign blank[2] = blank[1] && (s_tens.digit == '0);
  assign blank[3] = blank[2] && (d_ones == '0);

  always_comb begin
    seg0_nxt = blank[0] ? '0 : ssfmt_pkg::seg_of(s_thou.digit);
    seg1_nxt = blank[1] ? '0 : ssfmt_pkg::seg_of(s_hund.digit);
    seg2_nxt = blank[2] ? '0 : ssfmt_pkg::seg_of(s_tens.digit);
    seg3_nxt = blank[3] ? '0 : ssfmt_pkg::seg_of(d_ones);
    case (in_item.point)
      ssfmt_pkg::PT_FIRST:  seg0_nxt[0] = 1'b1;
      ssfmt_pkg::PT_SECOND: seg1_nxt[0] = 1'b1;
      ssfmt_pkg::PT_THIRD:  seg2_nxt[0] = 1'b1;
      ssfmt_pkg::PT_FOURTH: seg3_nxt[0] = 1'b1;
      default: ;
    endcase
  end

  assign in_ready   = !valid_r || out_ready;
  assign out_valid  = valid_r;
  assign seg_first  = seg0_r;
  assign seg_second = seg1_r;
  assign seg_third  = seg2_r;
  assign seg_fourth = seg3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      seg0_r <= seg0_nxt;
      seg1_r <= seg1_nxt;
      seg2_r <= seg2_nxt;
      seg3_r <= seg3_nxt;
    end
  end

  a_one_point: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r |-> $countones({seg0_r[0], seg1_r[0], seg2_r[0], seg3_r[0]}) <= 1)
    else $error("more than one point lit");

  a_keep_zeros: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_item.keep |=> valid_r && seg0_r[7:1] != 7'd0)
    else $error("leading digit blanked with leading zeros on");

  a_blank_order: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r && seg1_r[7:1] == 7'd0 |-> seg0_r[7:1] == 7'd0)
    else $error("blank digit right of a lit digit");

endmodule

@@ rtl/four_digit_seven_segment_formatter_core.sv @@
// ----------------------------------------------------------------------------
// four_digit_seven_segment_formatter_core
// Formats a 32-bit unsigned value as four seven-segment bytes with leading
// zero blanking and a selectable decimal point.
//
//   channel  direction  handshake          payload
//   in_      input      in_valid/in_ready  value, show_leading_zeros,
//                                          point_position
//   out_     output     out_valid/out_ready segments_first..segments_fourth
//
// one beat per cycle sustained while out_ready stays high
// stages: input register, reciprocal multiply to scaled register, digit
// decode to result register
// reset clears the stage valid bits only
// out_ready low holds the result and backs up one stage at a time; in_ready
// follows out_ready combinationally when all stages are full
// ----------------------------------------------------------------------------
module four_digit_seven_segment_formatter_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] in_value,
  input  logic        in_show_leading_zeros,
  input  logic [2:0]  in_point_position,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_segments_first,
  output logic [7:0]  out_segments_second,
  output logic [7:0]  out_segments_third,
  output logic [7:0]  out_segments_fourth
);

  logic               in_valid_r;
  logic [31:0]        value_r;
  logic               keep_r;
  logic [2:0]         point_r;
  logic               sc_ready;
  logic               sc_valid;
  logic               dg_ready;
  ssfmt_pkg::scaled_t sc_item;

  assign in_ready = !in_valid_r || sc_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      value_r <= in_value;
      keep_r  <= in_show_leading_zeros;
      point_r <= in_point_position;
    end
  end

  ssfmt_scale u_scale (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid_r),
    .in_ready  (sc_ready),
    .value     (value_r),
    .keep      (keep_r),
    .point     (point_r),
    .out_valid (sc_valid),
    .out_ready (dg_ready),
    .out_item  (sc_item)
  );

  ssfmt_digits u_digits (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (sc_valid),
    .in_ready   (dg_ready),
    .in_item    (sc_item),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .seg_first  (out_segments_first),
    .seg_second (out_segments_second),
    .seg_third  (out_segments_third),
    .seg_fourth (out_segments_fourth)
  );

  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> in_valid_r && sc_valid && out_valid && !out_ready)
    else $error("input stalled with a free stage");

  a_in_captured: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> in_valid_r && value_r == $past(in_value))
    else $error("input beat not captured");

  a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

endmodule

@@ verif/ssfmt_display_checker.sv @@
// ----------------------------------------------------------------------------
// ssfmt_display_checker
// Watches both channels of the seven-segment formatter. Every input beat
// is turned into the four segment bytes it should show, and every result
// beat is compared, byte by byte, with the oldest display still due.
// ----------------------------------------------------------------------------
module ssfmt_display_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [31:0] in_value,
  input  logic        in_show_leading_zeros,
  input  logic [2:0]  in_point_position,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [7:0]  out_segments_first,
  input  logic [7:0]  out_segments_second,
  input  logic [7:0]  out_segments_third,
  input  logic [7:0]  out_segments_fourth,
  output int          mismatches,
  output int          outstanding
);

  // index 0 is the leftmost digit
  typedef logic [0:3][7:0] display_t;

  display_t displays_due [$];

  function automatic display_t predict_display(logic [31:0] value, logic keep,
                                               logic [2:0] point);
    logic [31:0]     shown;
    logic [0:3][3:0] digits;
    logic            leading;
    display_t        disp;
    int              i;
    shown = value;
    if (value > ssfmt_pkg::DIV1000_MIN) begin
      shown = value / 1000;
    end else if (value > ssfmt_pkg::DIV100_MIN) begin
      shown = value / 100;
    end else if (value > ssfmt_pkg::DIV10_MIN) begin
      shown = value / 10;
    end
    if (shown > 32'(ssfmt_pkg::DISPLAY_MAX)) begin
      shown = 32'(ssfmt_pkg::DISPLAY_MAX);
    end
    digits[0] = 4'(shown / 1000);
    digits[1] = 4'((shown / 100) % 10);
    digits[2] = 4'((shown / 10) % 10);
    digits[3] = 4'(shown % 10);
    leading = 1'b1;
    for (i = 0; i < 4; i++) begin
      if (digits[i] != 4'd0) begin
        leading = 1'b0;
      end
      if (!keep && leading) begin
        disp[i] = 8'h00;
      end else begin
        case (digits[i])
          4'd0:    disp[i] = 8'hfc;
          4'd1:    disp[i] = 8'h60;
          4'd2:    disp[i] = 8'hda;
          4'd3:    disp[i] = 8'hf2;
          4'd4:    disp[i] = 8'h66;
          4'd5:    disp[i] = 8'hb6;
          4'd6:    disp[i] = 8'hbe;
          4'd7:    disp[i] = 8'he0;
          4'd8:    disp[i] = 8'hfe;
          default: disp[i] = 8'hf6;
        endcase
      end
      if (point != ssfmt_pkg::PT_NONE && int'(point) - 1 == i) begin
        disp[i][0] = 1'b1;
      end
    end
    return disp;
  endfunction

  always @(posedge clk) begin : watch
    display_t got;
    display_t want;
    string    field;
    int       i;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        got = {out_segments_first, out_segments_second, out_segments_third,
               out_segments_fourth};
        if (displays_due.size() == 0) begin
          $error("result beat with no input beat waiting: %h", got);
          mismatches++;
        end else begin
          want = displays_due.pop_front();
          for (i = 0; i < 4; i++) begin
            case (i)
              0:       field = "segments_first";
              1:       field = "segments_second";
              2:       field = "segments_third";
              default: field = "segments_fourth";
            endcase
            if (got[i] !== want[i]) begin
              $error("%s: expected %h, got %h", field, want[i], got[i]);
              mismatches++;
            end
          end
        end
      end
      if (in_valid && in_ready) begin
        displays_due.push_back(predict_display(in_value, in_show_leading_zeros,
                                               in_point_position));
      end
    end
    outstanding <= displays_due.size();
  end

endmodule

@@ verif/four_digit_seven_segment_formatter_core_test.sv @@
// ----------------------------------------------------------------------------
// four_digit_seven_segment_formatter_core_test
// Drives values through the formatter: a directed pass over the scaling
// thresholds, saturation, blanking and point positions, then random beats
// weighted toward each scaling range. Both sides stall at random, with a
// stall-free stretch and long output hold-offs that back the pipe up.
// ----------------------------------------------------------------------------
module four_digit_seven_segment_formatter_core_test;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [31:0] in_value;
  logic        in_show_leading_zeros;
  logic [2:0]  in_point_position;
  logic        out_valid;
  logic        out_ready;
  logic [7:0]  out_segments_first;
  logic [7:0]  out_segments_second;
  logic [7:0]  out_segments_third;
  logic [7:0]  out_segments_fourth;

  int   mismatches;
  int   outstanding;
  int   beats_sent = 0;
  logic steady = 1'b0;

  four_digit_seven_segment_formatter_core dut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_ready              (in_ready),
    .in_value              (in_value),
    .in_show_leading_zeros (in_show_leading_zeros),
    .in_point_position     (in_point_position),
    .out_valid             (out_valid),
    .out_ready             (out_ready),
    .out_segments_first    (out_segments_first),
    .out_segments_second   (out_segments_second),
    .out_segments_third    (out_segments_third),
    .out_segments_fourth   (out_segments_fourth)
  );

  ssfmt_display_checker display_check (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_ready              (in_ready),
    .in_value              (in_value),
    .in_show_leading_zeros (in_show_leading_zeros),
    .in_point_position     (in_point_position),
    .out_valid             (out_valid),
    .out_ready             (out_ready),
    .out_segments_first    (out_segments_first),
    .out_segments_second   (out_segments_second),
    .out_segments_third    (out_segments_third),
    .out_segments_fourth   (out_segments_fourth),
    .mismatches            (mismatches),
    .outstanding           (outstanding)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic send_beat(input logic [31:0] value, input logic keep,
                           input logic [2:0] point);
    while (!steady && $urandom_range(99) < 23) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid              <= 1'b1;
    in_value              <= value;
    in_show_leading_zeros <= keep;
    in_point_position     <= point;
    do @(posedge clk); while (!in_ready);
    beats_sent <= beats_sent + 1;
  endtask

  initial begin : stimulus
    logic [31:0] value;
    logic [31:0] base;
    int          n;
    int          p;
    rst_n                 <= 1'b0;
    in_valid              <= 1'b0;
    in_value              <= '0;
    in_show_leading_zeros <= 1'b0;
    in_point_position     <= ssfmt_pkg::PT_NONE;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // blank display, point on a blank digit, saturation, thresholds
    send_beat(32'd0, 1'b0, ssfmt_pkg::PT_NONE);
    send_beat(32'd0, 1'b1, ssfmt_pkg::PT_NONE);
    send_beat(32'd0, 1'b0, ssfmt_pkg::PT_FIRST);
    send_beat(32'd0, 1'b0, ssfmt_pkg::PT_FOURTH);
    send_beat(32'd7, 1'b0, ssfmt_pkg::PT_SECOND);
    send_beat(32'd7, 1'b1, ssfmt_pkg::PT_THIRD);
    send_beat(32'd1005, 1'b0, ssfmt_pkg::PT_FIRST);
    send_beat(32'd9999, 1'b0, ssfmt_pkg::PT_FOURTH);
    send_beat(32'd10000, 1'b0, ssfmt_pkg::PT_THIRD);
    send_beat(32'd99999, 1'b1, ssfmt_pkg::PT_NONE);
    send_beat(32'd100000, 1'b0, ssfmt_pkg::PT_SECOND);
    send_beat(32'd999999, 1'b1, ssfmt_pkg::PT_FIRST);
    send_beat(32'd1000000, 1'b0, ssfmt_pkg::PT_NONE);
    send_beat(32'd9999999, 1'b0, ssfmt_pkg::PT_FOURTH);
    send_beat(32'd10000000, 1'b1, ssfmt_pkg::PT_NONE);
    send_beat(32'hffffffff, 1'b0, ssfmt_pkg::PT_THIRD);
    send_beat(32'h80000000, 1'b1, ssfmt_pkg::PT_FIRST);
    send_beat(32'd12345678, 1'b0, ssfmt_pkg::PT_NONE);
    send_beat(32'd86, 1'b1, ssfmt_pkg::PT_SECOND);
    send_beat(32'd100, 1'b0, ssfmt_pkg::PT_FOURTH);
    for (p = int'(ssfmt_pkg::PT_FOURTH) + 1; p < 8; p++) begin
      send_beat(32'd4321, 1'b0, 3'(p));
    end

    for (n = 0; n < 1400; n++) begin
      if (n == 700) begin
        steady <= 1'b1;
      end else if (n == 950) begin
        steady <= 1'b0;
      end
      case ($urandom_range(9))
        0, 1, 2: value = $urandom_range(9999);
        3:       value = $urandom_range(99999, 10000);
        4:       value = $urandom_range(999999, 100000);
        5:       value = $urandom_range(9999999, 1000000);
        6:       value = $urandom_range(99);
        7: begin
          case ($urandom_range(3))
            0:       base = 32'd10000;
            1:       base = 32'd100000;
            2:       base = 32'd1000000;
            default: base = 32'd10000000;
          endcase
          value = base + $urandom_range(4) - 32'd2;
        end
        default: value = $urandom;
      endcase
      send_beat(value, 1'($urandom_range(1)),
                3'($urandom_range(99) < 80 ? $urandom_range(4) : $urandom_range(7, 5)));
    end
    in_valid <= 1'b0;

    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // output side: random stalls, two long hold-offs while beats keep coming
  initial begin : receiver
    int hold_left;
    int holds_done;
    hold_left  = 0;
    holds_done = 0;
    out_ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_left == 0 && holds_done < 2 &&
          beats_sent >= (holds_done == 0 ? 400 : 1100)) begin
        hold_left = 250;
        holds_done++;
      end
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else if (steady) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= ($urandom_range(99) >= 23);
      end
      @(posedge clk);
    end
  end

  initial begin : watchdog
    #5000000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule

@@ files.f @@
rtl/ssfmt_pkg.sv
rtl/ssfmt_scale.sv
rtl/ssfmt_digits.sv
rtl/four_digit_seven_segment_formatter_core.sv
verif/ssfmt_display_checker.sv
verif/four_digit_seven_segment_formatter_core_test.sv
